// ===== design/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// shared types, constants and helpers of the perspective span subdivider
// ----------------------------------------------------------------------------
`default_nettype none
package psd_pkg;

	localparam int unsigned LEN_W      = 11;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned CNT_W      = 7;
	localparam int unsigned TAIL_W     = 6;
	localparam int unsigned SH_W       = 3;
	localparam int unsigned MAX_SPAN_D = 1024;
	localparam int unsigned Z_SCALE    = 10;
	localparam int unsigned MAG_SHIFT  = 13;
	localparam int unsigned HALF_W     = 16;

	localparam logic [SH_W-1:0] SH_64 = 3'd6;
	localparam logic [SH_W-1:0] SH_32 = 3'd5;
	localparam logic [SH_W-1:0] SH_16 = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ADV,
		ST_EMIT
	} seq_state_t;

	typedef enum logic [2:0] {
		OP_U0,
		OP_V0,
		OP_NU,
		OP_NV,
		OP_EU,
		OP_EV,
		OP_TU,
		OP_TV
	} div_op_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] num;
		logic [WORD_W-1:0] den;
	} div_req_t;

	// cluster shift from the depth step magnitude
	function automatic logic [SH_W-1:0] shift_for_step(input logic [WORD_W-1:0] mag);
		logic [2:0] ix;
		logic [SH_W-1:0] s;
		begin
			ix = (mag[WORD_W-1:HALF_W] != '0) ? 3'd7 : mag[HALF_W-1:MAG_SHIFT];
			case (ix)
				3'd0: s = SH_64;
				3'd1, 3'd2: s = SH_32;
				default: s = SH_16;
			endcase
			return s;
		end
	endfunction

	function automatic logic [WORD_W-1:0] asr(input logic [WORD_W-1:0] x,
		input logic [SH_W-1:0] s);
		return WORD_W'($signed(x) >>> s);
	endfunction

endpackage
`default_nettype wire

// ===== design/perspective_span_subdivider_top.sv =====
// ----------------------------------------------------------------------------
// perspective_span_subdivider_top
// splits a span into perspective-correct clusters, one record per cluster
// ----------------------------------------------------------------------------
// span-end evaluation is serial, then every divide runs on the one shared bit-serial
// divider; a new span is accepted only while idle, so spans do not overlap
// each record shows for one cycle on result_valid; the receiver cannot stall
// reset: asynchronous, active low, returns the sequencer to idle
`default_nettype none
module perspective_span_subdivider_top #(
	parameter int unsigned MAX_SPAN = psd_pkg::MAX_SPAN_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [10:0] span_length,
	input  wire logic [31:0] depth_start,
	input  wire logic [31:0] depth_step,
	input  wire logic [31:0] u_start,
	input  wire logic [31:0] u_step,
	input  wire logic [31:0] v_start,
	input  wire logic [31:0] v_step,
	output logic             result_valid,
	output logic [31:0]      start_word,
	output logic [31:0]      delta_word,
	output logic [6:0]       pixel_count,
	output logic             last
);
	import psd_pkg::*;

	seq_state_t state_q, state_d;
	div_op_t    op_q, op_d;
	div_req_t   dreq;
	logic       div_done, mac_done, accept;
	logic [WORD_W-1:0] div_q;
	logic [2:0][WORD_W-1:0] mac_acc;

	logic [LEN_W-1:0]  len_sat;
	logic [WORD_W-1:0] mag;
	logic [SH_W-1:0]   sh_in, sh_q;
	logic [CNT_W-1:0]  full_q, clu_q, clu_nx;
	logic [TAIL_W-1:0] tail_q;
	logic [WORD_W-1:0] zc_q, uc_q, vc_q, dzc_q, duc_q, dvc_q;
	logic [WORD_W-1:0] u_q, v_q, nu_q, nv_q, eu_q, ev_q, ddu_q, ddv_q;
	logic [WORD_W-1:0] ez, diff, full_du, full_dv;
	logic              neg_q, neg_d;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign len_sat = (span_length > LEN_W'(MAX_SPAN)) ? LEN_W'(MAX_SPAN) : span_length;
	assign mag     = depth_step[WORD_W-1] ? (WORD_W'(0) - depth_step) : depth_step;
	assign sh_in   = shift_for_step(mag);
	assign ez      = mac_acc[0] >> Z_SCALE;
	assign clu_nx  = clu_q + CNT_W'(1);
	assign full_du = asr(nu_q - u_q, sh_q);
	assign full_dv = asr(nv_q - v_q, sh_q);

	psd_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.len   (len_sat),
		.base  ({v_start, u_start, depth_start}),
		.step  ({v_step, u_step, depth_step}),
		.done  (mac_done),
		.acc   (mac_acc)
	);

	psd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.done  (div_done),
		.quo   (div_q)
	);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		dreq      = '0;
		diff      = (op_q == OP_TU) ? (eu_q - u_q) : (ev_q - v_q);
		neg_d     = diff[WORD_W-1];
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mac_done) begin
					state_d = ST_DIV_GO;
					op_d    = OP_U0;
				end
			end
			ST_DIV_GO: begin
				dreq.start = 1'b1;
				case (op_q)
					OP_U0, OP_NU: begin dreq.num = uc_q; dreq.den = zc_q; end
					OP_V0, OP_NV: begin dreq.num = vc_q; dreq.den = zc_q; end
					OP_EU: begin dreq.num = mac_acc[1]; dreq.den = ez; end
					OP_EV: begin dreq.num = mac_acc[2]; dreq.den = ez; end
					default: begin
						dreq.num = neg_d ? (WORD_W'(0) - diff) : diff;
						dreq.den = WORD_W'(tail_q);
					end
				endcase
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_DIV_GO;
					case (op_q)
						OP_U0: op_d = OP_V0;
						OP_V0: begin
							if (full_q != '0) state_d = ST_ADV;
							else if (tail_q != '0) op_d = OP_EU;
							else state_d = ST_IDLE;
						end
						OP_NU: op_d = OP_NV;
						OP_NV: state_d = ST_EMIT;
						OP_EU: op_d = OP_EV;
						OP_EV: op_d = OP_TU;
						OP_TU: op_d = OP_TV;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_ADV: begin
				state_d = ST_DIV_GO;
				op_d    = OP_NU;
			end
			ST_EMIT: begin
				if (op_q == OP_TV) state_d = ST_IDLE;
				else if (clu_nx < full_q) state_d = ST_ADV;
				else if (tail_q != '0) begin
					state_d = ST_DIV_GO;
					op_d    = OP_EU;
				end else state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_U0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			op_q         <= op_d;
			result_valid <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q   <= sh_in;
			full_q <= CNT_W'(len_sat >> sh_in);
			tail_q <= TAIL_W'(len_sat & ((LEN_W'(1) << sh_in) - LEN_W'(1)));
			clu_q  <= '0;
			zc_q   <= depth_start >> Z_SCALE;
			uc_q   <= u_start;
			vc_q   <= v_start;
			duc_q  <= u_step << sh_in;
			dvc_q  <= v_step << sh_in;
			dzc_q  <= WORD_W'($signed(depth_step << sh_in) >>> Z_SCALE);
		end
		if (state_q == ST_DIV_GO) neg_q <= neg_d;
		if (state_q == ST_ADV) begin
			zc_q <= zc_q + dzc_q;
			uc_q <= uc_q + duc_q;
			vc_q <= vc_q + dvc_q;
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			case (op_q)
				OP_U0: u_q  <= div_q;
				OP_V0: v_q  <= div_q;
				OP_NU: nu_q <= div_q;
				OP_NV: nv_q <= div_q;
				OP_EU: eu_q <= div_q;
				OP_EV: ev_q <= div_q;
				OP_TU: ddu_q <= neg_q ? (WORD_W'(0) - div_q) : div_q;
				default: ddv_q <= neg_q ? (WORD_W'(0) - div_q) : div_q;
			endcase
		end
		if (state_q == ST_EMIT) begin
			start_word <= {u_q[HALF_W-1:0], {HALF_W{1'b0}}} | v_q;
			if (op_q == OP_TV) begin
				delta_word  <= {ddu_q[HALF_W-1:0], ddv_q[HALF_W-1:0]};
				pixel_count <= CNT_W'(tail_q);
				last        <= 1'b1;
			end else begin
				delta_word  <= {full_du[HALF_W-1:0], full_dv[HALF_W-1:0]};
				pixel_count <= CNT_W'(1) << sh_q;
				last        <= (clu_nx == full_q) && (tail_q == '0);
				u_q         <= nu_q;
				v_q         <= nv_q;
				clu_q       <= clu_nx;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module psd_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire psd_pkg::div_req_t req,
	output logic                   done,
	output logic [31:0]            quo
);
	import psd_pkg::*;

	logic [WORD_W-1:0] rem_q, quo_q, den_q;
	logic [5:0]        cnt_q;
	logic              run_q, done_q;
	logic [WORD_W:0]   rem_sh, diff;
	logic              qbit;

	always_comb begin
		rem_sh = {rem_q, quo_q[WORD_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		qbit   = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(WORD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (run_q) begin
			rem_q <= qbit ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ===== design/psd_mac.sv =====
// ----------------------------------------------------------------------------
// psd_mac
// bit-serial span-end evaluation: base + step * length for three lanes
// ----------------------------------------------------------------------------
`default_nettype none
module psd_mac (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [psd_pkg::LEN_W-1:0]   len,
	input  wire logic [2:0][31:0]            base,
	input  wire logic [2:0][31:0]            step,
	output logic                             done,
	output logic [2:0][31:0]                 acc
);
	import psd_pkg::*;

	logic [LEN_W-1:0]        mul_q;
	logic [2:0][WORD_W-1:0]  add_q, acc_q;
	logic [3:0]              cnt_q;
	logic                    run_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(LEN_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mul_q <= len;
			add_q <= step;
			acc_q <= base;
		end else if (run_q) begin
			mul_q <= mul_q >> 1;
			for (int i = 0; i < 3; i++) begin
				add_q[i] <= add_q[i] << 1;
				if (mul_q[0])
					acc_q[i] <= acc_q[i] + add_q[i];
			end
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule
`default_nettype wire

// ===== design/psd_chk.sv =====
// ----------------------------------------------------------------------------
// psd_chk
// port-level checks of the span subdivider
// ----------------------------------------------------------------------------
`default_nettype none
module psd_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       result_valid,
	input wire logic [6:0] pixel_count,
	input wire logic       last
);
	// an accepted beat keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");

	// the block is still busy while a non-final record shows
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy) else $error("idle before final record");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pixel_count != 7'd0) && (pixel_count <= 7'd64))
		else $error("bad pixel count");

	// records never come in adjacent cycles
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("back-to-back records");

endmodule

bind perspective_span_subdivider_top psd_chk u_psd_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.pixel_count (pixel_count),
	.last        (last)
);
`default_nettype wire

// ===== tb/tb_perspective_span_subdivider_top.sv =====
// ----------------------------------------------------------------------------
// tb_perspective_span_subdivider_top
// drives spans through the subdivider and checks every cluster record
// against a behavioral model of the cluster split and perspective divides
// ----------------------------------------------------------------------------
`default_nettype none
module tb_perspective_span_subdivider_top;
	import psd_pkg::*;

	typedef struct packed {
		logic [10:0] len;
		logic [31:0] zs, dz, us, du, vs, dv;
	} span_t;

	typedef struct packed {
		logic [31:0] sw;
		logic [31:0] dw;
		logic [6:0]  cnt;
		logic        lst;
	} cluster_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [10:0] span_length;
	logic [31:0] depth_start, depth_step, u_start, u_step, v_start, v_step;
	logic        result_valid;
	logic [31:0] start_word, delta_word;
	logic [6:0]  pixel_count;
	logic        last;

	cluster_t clusters_due[$];
	int       errors;
	span_t    dir_spans[$];
	cluster_t dir_first[$];
	bit       dir_has_first[$];

	perspective_span_subdivider_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.span_length(span_length), .depth_start(depth_start), .depth_step(depth_step),
		.u_start(u_start), .u_step(u_step), .v_start(v_start), .v_step(v_step),
		.result_valid(result_valid), .start_word(start_word), .delta_word(delta_word),
		.pixel_count(pixel_count), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] qdiv(input logic [31:0] a, input logic [31:0] b);
		return (b == 32'd0) ? 32'hFFFFFFFF : a / b;
	endfunction

	function automatic logic [31:0] sra(input logic [31:0] x, input int s);
		return $signed(x) >>> s;
	endfunction

	function automatic logic [31:0] sdivn(input logic [31:0] x, input logic [31:0] d);
		longint q;
		q = longint'($signed(x)) / longint'(d);
		return q[31:0];
	endfunction

	// split one span into its cluster records
	task automatic split_span(input span_t s);
		logic [31:0] len, mag, ix, zc, uc, vc, dzc, duc, dvc, u, v, nu, nv, du_, dv_;
		logic [31:0] ez, eu, ev, full, tail;
		int sh;
		cluster_t c;
		int n;
		n = clusters_due.size();
		len = (s.len > 11'd1024) ? 32'd1024 : {21'd0, s.len};
		mag = s.dz[31] ? -s.dz : s.dz;
		ix = mag >> 13;
		if (ix > 7) ix = 7;
		sh = (ix == 0) ? 6 : (ix <= 2) ? 5 : 4;
		duc = s.du << sh;
		dvc = s.dv << sh;
		dzc = sra(s.dz << sh, 10);
		zc = s.zs >> 10;
		uc = s.us;
		vc = s.vs;
		u = qdiv(uc, zc);
		v = qdiv(vc, zc);
		full = len >> sh;
		tail = len & ((32'd1 << sh) - 1);
		for (int i = 0; i < full; i++) begin
			zc += dzc; uc += duc; vc += dvc;
			nu = qdiv(uc, zc);
			nv = qdiv(vc, zc);
			du_ = sra(nu - u, sh);
			dv_ = sra(nv - v, sh);
			c.sw = (u << 16) | v;
			c.dw = (du_ << 16) | (dv_ & 32'hFFFF);
			c.cnt = 7'(32'd1 << sh);
			c.lst = 1'b0;
			clusters_due.push_back(c);
			u = nu; v = nv;
		end
		if (tail > 0) begin
			ez = (s.zs + s.dz * len) >> 10;
			eu = qdiv(s.us + s.du * len, ez);
			ev = qdiv(s.vs + s.dv * len, ez);
			du_ = sdivn(eu - u, tail);
			dv_ = sdivn(ev - v, tail);
			c.sw = (u << 16) | v;
			c.dw = (du_ << 16) | (dv_ & 32'hFFFF);
			c.cnt = 7'(tail);
			c.lst = 1'b0;
			clusters_due.push_back(c);
		end
		if (clusters_due.size() > n) clusters_due[$].lst = 1'b1;
	endtask

	// result monitor: receiver cannot stall, so every strobe is a beat
	always @(posedge clk) begin
		cluster_t got, exp_c;
		if (arst_n && result_valid) begin
			got = '{start_word, delta_word, pixel_count, last};
			if (clusters_due.size() == 0) begin
				$display("%0t: unexpected cluster %h", $time, got);
				errors++;
			end else begin
				exp_c = clusters_due.pop_front();
				if (got.sw !== exp_c.sw) begin
					$display("%0t: start_word exp %h got %h", $time, exp_c.sw, got.sw);
					errors++;
				end
				if (got.dw !== exp_c.dw) begin
					$display("%0t: delta_word exp %h got %h", $time, exp_c.dw, got.dw);
					errors++;
				end
				if (got.cnt !== exp_c.cnt) begin
					$display("%0t: pixel_count exp %0d got %0d", $time, exp_c.cnt, got.cnt);
					errors++;
				end
				if (got.lst !== exp_c.lst) begin
					$display("%0t: last exp %b got %b", $time, exp_c.lst, got.lst);
					errors++;
				end
			end
		end
	end

	// start stays high after the beat; the caller drops it before a gap
	task automatic send_span(input span_t s, input bit has_first, input cluster_t first);
		start <= 1'b1;
		span_length <= s.len;
		depth_start <= s.zs; depth_step <= s.dz;
		u_start <= s.us; u_step <= s.du;
		v_start <= s.vs; v_step <= s.dv;
		@(posedge clk);
		while (busy) @(posedge clk);
		split_span(s);
		// typed-in first record where it is obvious
		if (has_first && clusters_due.size() > 0 && clusters_due[0] !== first) begin
			$display("%0t: directed row exp %h model %h", $time, first, clusters_due[0]);
			errors++;
		end
	endtask

	function automatic span_t rand_span(input bit long_ok);
		span_t s;
		int r;
		r = $urandom_range(0, 9);
		s.len = (r == 0 && long_ok) ? 11'($urandom_range(1, 2047)) :
			(r < 3) ? 11'($urandom_range(1, 64)) : 11'($urandom_range(1, 200));
		s.zs = $urandom();
		case ($urandom_range(0, 3))
			0: s.dz = $urandom();
			1: s.dz = $urandom_range(0, 32'h1_FFFF) ^ {32{$urandom_range(0, 1) == 1}};
			2: s.dz = 32'($urandom_range(0, 8191));
			default: s.dz = 32'($urandom_range(0, 65535)) * (($urandom_range(0, 1)) ? 1 : -1);
		endcase
		s.us = $urandom(); s.du = $urandom();
		s.vs = $urandom(); s.dv = $urandom();
		if ($urandom_range(0, 1)) begin
			// plausible perspective values
			s.zs = 32'h4000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
			s.du = 32'($signed($urandom_range(0, 32'hFFFFF)) - 32'h80000);
			s.dv = 32'($signed($urandom_range(0, 32'hFFFFF)) - 32'h80000);
		end
		return s;
	endfunction

	initial begin
		span_t s;
		cluster_t none_c;
		int wait_cyc;
		errors = 0;
		none_c = '0;
		arst_n = 1'b0; start = 1'b0;
		span_length = 11'd1; depth_start = '0; depth_step = '0;
		u_start = '0; u_step = '0; v_start = '0; v_step = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero depth: the depth divides all by zero, one record of one pixel
		dir_spans.push_back('{11'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
		dir_has_first.push_back(1'b1);
		dir_first.push_back('{32'hFFFFFFFF, 32'h0, 7'd1, 1'b1});
		// exact multiple of 64, flat depth
		dir_spans.push_back('{11'd64, 32'h4000_0000, 32'd0, 32'h1000_0000, 32'd0,
			32'h2000_0000, 32'd0});
		dir_has_first.push_back(1'b0); dir_first.push_back(none_c);
		dir_spans.push_back('{11'd1024, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
			32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000});
		dir_has_first.push_back(1'b0); dir_first.push_back(none_c);
		dir_spans.push_back('{11'd2047, 32'h8000_0000, 32'h80000000, 32'h0,
			32'h80000000, 32'h0, 32'h7FFFFFFF});
		dir_has_first.push_back(1'b0); dir_first.push_back(none_c);
		dir_spans.push_back('{11'd1025, 32'h4000_0000, 32'hFFFFFFFF, 32'h1234_5678,
			32'hFFFF_FF00, 32'h8765_4321, 32'h100});
		dir_has_first.push_back(1'b0); dir_first.push_back(none_c);
		// cluster-size boundaries of the depth step
		for (int k = 0; k < 8; k++) begin
			dir_spans.push_back('{11'd100, 32'h6000_0000, 32'(k * 8192 + 8191),
				32'h3000_0000, 32'h0001_0000, 32'h0800_0000, 32'hFFFF_0000});
			dir_has_first.push_back(1'b0); dir_first.push_back(none_c);
			dir_spans.push_back('{11'd33, 32'h6000_0000, -32'(k * 8192 + 8192),
				32'h3000_0000, 32'h0001_0000, 32'h0800_0000, 32'hFFFF_0000});
			dir_has_first.push_back(1'b0); dir_first.push_back(none_c);
		end
		dir_spans.push_back('{11'd16, 32'h6000_0000, 32'h0001_0000, 32'hF000_0000,
			32'd5, 32'hF000_0000, 32'd7});
		dir_has_first.push_back(1'b0); dir_first.push_back(none_c);
		dir_spans.push_back('{11'd63, 32'h0000_0400, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h4000_0000, 32'h1, 32'hC000_0000});
		dir_has_first.push_back(1'b0); dir_first.push_back(none_c);

		foreach (dir_spans[i]) send_span(dir_spans[i], dir_has_first[i], dir_first[i]);

		for (int n = 0; n < 250; n++) begin
			// sender gaps, none in a stretch in the middle
			if ((n < 90 || n > 150) && $urandom_range(0, 99) < 36) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
			s = rand_span(n % 10 == 0);
			send_span(s, 1'b0, none_c);
		end
		start <= 1'b0;

		wait_cyc = 0;
		while (clusters_due.size() > 0 && wait_cyc < 200000) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && clusters_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

// ===== perspective_span_subdivider_top.f =====
design/psd_pkg.sv
design/psd_div.sv
design/psd_mac.sv
design/perspective_span_subdivider_top.sv
design/psd_chk.sv
tb/tb_perspective_span_subdivider_top.sv
